>>> hw/rtl/dbq_pkg.sv
// Package for the decimal32 BID quantize unit.
// Holds the sequencer state type and the fixed widths and constants; no dependencies.
`default_nettype none

package dbq_pkg;

	// Field widths of a decimal32 BID word
	localparam int unsigned WORD_W = 32;
	localparam int unsigned EXP_W  = 8;
	localparam int unsigned COEF_W = 24;
	localparam int unsigned QUOT_W = 21;
	localparam int unsigned RECIP_W = 32;
	localparam int unsigned PROD_W = COEF_W + RECIP_W;
	localparam int unsigned RECIP_SHIFT = 35;

	// Reciprocal of ten: floor(x * RECIP_10 / 2^35) == x / 10 for any 32-bit x
	localparam logic [RECIP_W-1:0] RECIP_10 = 32'hCCCC_CCCD;

	// Scaling up stops once the coefficient reaches this value
	localparam logic [COEF_W-1:0] EXPAND_LIMIT = 24'd1000000;

	// Rounding threshold on the dropped digit
	localparam logic [3:0] ROUND_HALF = 4'd5;

	// Sequencer states, one-hot
	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SCALE = 3'b010,
		S_DIV   = 3'b100
	} state_t;

endpackage

`default_nettype wire

>>> hw/rtl/dbq_in_if.sv
// Request channel of the decimal32 BID quantize unit: value and reference words.
// Uses dbq_pkg for the word width.
`default_nettype none

interface dbq_in_if;
	logic                        valid;
	logic                        ready;
	logic [dbq_pkg::WORD_W-1:0]  value_bits;
	logic [dbq_pkg::WORD_W-1:0]  reference_bits;

	modport source (output valid, output value_bits, output reference_bits, input ready);
	modport sink   (input valid, input value_bits, input reference_bits, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/dbq_out_if.sv
// Result channel of the decimal32 BID quantize unit: the requantized word.
// Uses dbq_pkg for the word width.
`default_nettype none

interface dbq_out_if;
	logic                        valid;
	logic                        ready;
	logic [dbq_pkg::WORD_W-1:0]  result_bits;

	modport source (output valid, output result_bits, input ready);
	modport sink   (input valid, input result_bits, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/decimal32_bid_quantize_unit.sv
// Top level of the decimal32 BID quantize unit: decode, iterative rescale, repack.
// Depends on dbq_pkg, dbq_in_if and dbq_out_if.
//
// Re-expresses a decimal32 BID value at the exponent of a reference word. One request
// is worked on at a time and operand.ready is high only while the sequencer is idle.
// A request is taken in and decoded into registers. Each divide-by-ten step issues a
// reciprocal multiply in the scaling state, then does the remainder correction and
// half-up rounding of the dropped digit in the divide state; each multiply-by-ten
// step is done in the scaling state alone, and a final pass through that state packs
// the result into the output register. A coefficient of zero jumps straight to the
// target exponent. The reciprocal multiplier sets the pace: even the largest decoded
// coefficient reaches zero after eight divide steps and scaling up needs at most six
// steps. Packing also waits for the output register to empty. The output register
// lets the next request be taken while a result still waits on result.ready.
`default_nettype none

module decimal32_bid_quantize_unit (
	input  wire       clk,
	input  wire       arst_n,
	dbq_in_if.sink    operand,
	dbq_out_if.source result
);

	localparam int unsigned EW = dbq_pkg::EXP_W;
	localparam int unsigned CW = dbq_pkg::COEF_W;
	localparam int unsigned QW = dbq_pkg::QUOT_W;
	localparam int unsigned PW = dbq_pkg::PROD_W;

	dbq_pkg::state_t           state_q;
	logic                      out_valid_q;
	logic [dbq_pkg::WORD_W-1:0] out_bits_q;

	logic          sign_q;
	logic [EW-1:0] ex_q;
	logic [EW-1:0] er_q;
	logic [CW-1:0] m_q;
	logic [PW-1:0] prod_q;

	logic          take;
	logic          out_free;
	logic          scale_done;
	logic [EW-1:0] dec_ex;
	logic [CW-1:0] dec_m;
	logic [EW-1:0] dec_er;
	logic [QW-1:0] quot;
	logic [CW-1:0] quot_x10;
	logic [3:0]    rem;
	logic [CW-1:0] m_div;
	logic [CW-1:0] m_x10;
	logic [dbq_pkg::WORD_W-1:0] packed_bits;

	assign operand.ready = (state_q == dbq_pkg::S_IDLE);
	assign take          = operand.valid && operand.ready;
	assign out_free      = !out_valid_q || result.ready;
	assign result.valid       = out_valid_q;
	assign result.result_bits = out_bits_q;

	// Scaling is over once the exponent matches or the coefficient is large enough
	assign scale_done = !(ex_q < er_q) && !(ex_q > er_q && m_q < dbq_pkg::EXPAND_LIMIT);

	// Decode both operands: long form when bits 30..29 are both set
	always_comb begin
		if (operand.value_bits[30:29] == 2'b11) begin
			dec_ex = operand.value_bits[28:21];
			dec_m  = {3'b100, operand.value_bits[20:0]};
		end else begin
			dec_ex = operand.value_bits[30:23];
			dec_m  = {1'b0, operand.value_bits[22:0]};
		end
		if (operand.reference_bits[30:29] == 2'b11) begin
			dec_er = operand.reference_bits[28:21];
		end else begin
			dec_er = operand.reference_bits[30:23];
		end
	end

	// Finish a divide step: quotient from the product, remainder, round half up
	always_comb begin
		quot     = prod_q[dbq_pkg::RECIP_SHIFT +: QW];
		quot_x10 = {{(CW-QW){1'b0}}, quot} * CW'(10);
		rem      = 4'(m_q - quot_x10);
		m_div    = {{(CW-QW){1'b0}}, quot} + CW'(rem >= dbq_pkg::ROUND_HALF);
	end

	// Multiply step by shift and add
	assign m_x10 = {m_q[CW-4:0], 3'b000} + {m_q[CW-2:0], 1'b0};

	// Repack sign, exponent and coefficient
	always_comb begin
		if (m_q[23]) begin
			packed_bits = {sign_q, 2'b11, ex_q, m_q[20:0]};
		end else begin
			packed_bits = {sign_q, ex_q, m_q[22:0]};
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dbq_pkg::S_IDLE;
		end else begin
			case (state_q)
				dbq_pkg::S_IDLE: begin
					if (take) begin
						state_q <= dbq_pkg::S_SCALE;
					end
				end
				dbq_pkg::S_SCALE: begin
					if (ex_q < er_q && m_q != '0) begin
						state_q <= dbq_pkg::S_DIV;
					end else if (!scale_done) begin
						state_q <= dbq_pkg::S_SCALE;
					end else if (out_free) begin
						state_q <= dbq_pkg::S_IDLE;
					end
				end
				dbq_pkg::S_DIV: begin
					state_q <= dbq_pkg::S_SCALE;
				end
				default: begin
					state_q <= dbq_pkg::S_IDLE;
				end
			endcase
		end
	end

	// Output valid: raise on pack, drop once the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == dbq_pkg::S_SCALE && scale_done && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Datapath: load, divide, multiply and pack
	always_ff @(posedge clk) begin
		case (state_q)
			dbq_pkg::S_IDLE: begin
				if (take) begin
					sign_q <= operand.value_bits[31];
					ex_q   <= dec_ex;
					er_q   <= dec_er;
					m_q    <= dec_m;
				end
			end
			dbq_pkg::S_SCALE: begin
				if (ex_q < er_q) begin
					if (m_q == '0) begin
						ex_q <= er_q;
					end else begin
						prod_q <= PW'(m_q) * PW'(dbq_pkg::RECIP_10);
					end
				end else if (ex_q > er_q && m_q < dbq_pkg::EXPAND_LIMIT) begin
					if (m_q == '0) begin
						ex_q <= er_q;
					end else begin
						m_q  <= m_x10;
						ex_q <= ex_q - EW'(1);
					end
				end else if (out_free) begin
					out_bits_q <= packed_bits;
				end
			end
			dbq_pkg::S_DIV: begin
				m_q  <= m_div;
				ex_q <= ex_q + EW'(1);
			end
			default: begin
			end
		endcase
	end

	// A result appears only when the sequencer leaves the scaling state
	a_result_from_scale: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == dbq_pkg::S_SCALE))
		else $error("result raised outside the scaling state");

	// The divide correction always follows a multiply issued from the scaling state
	a_div_after_scale: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dbq_pkg::S_DIV) |-> $past(state_q == dbq_pkg::S_SCALE))
		else $error("divide step entered without a multiply");

	// Stepping up the exponent never overshoots the reference
	a_no_overshoot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dbq_pkg::S_SCALE && $past(state_q == dbq_pkg::S_DIV)) |-> (ex_q <= er_q))
		else $error("exponent passed the reference exponent");

	// An accepted request moves the sequencer into the scaling state
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> (state_q == dbq_pkg::S_SCALE))
		else $error("accepted request did not start scaling");

endmodule

`default_nettype wire
